/* sv/mtcd_pkg.sv */
`timescale 1ns / 1ps

package mtcd_pkg;

    localparam int NUM_CYLINDERS = 12;
    localparam int TOOTH_W       = 8;
    localparam int REV_W         = 16;
    localparam int PERIOD_W      = 32;
    localparam int CYL_W         = 4;
    localparam int POS_W         = 9;
    localparam int RATIO_W       = 6;
    localparam int PROD_W        = PERIOD_W + RATIO_W;
    localparam int IN_DATA_W     = 48;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 72;
    localparam int ADDR_W        = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [TOOTH_W-1:0] TEETH_RESET = TOOTH_W'(60);
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(14);

    typedef enum logic [1:0] {
        MODE_TOOTH = 2'd0,
        MODE_CAM   = 2'd1,
        MODE_TABLE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_TEETH  = 2'd0,
        REG_RATIO  = 2'd1,
        REG_HALL   = 2'd2,
        REG_MANUAL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TOOTH_W-1:0] teeth_per_rev;
        logic [RATIO_W-1:0] gap_ratio_tenths;
        logic               hall_on_crank;
        logic               manual_injection;
    } cfg_t;

    typedef struct packed {
        mode_t               mode;
        logic [PERIOD_W-1:0] period;
        logic [CYL_W-1:0]    cyl_index;
        logic [POS_W-1:0]    tooth_position;
    } item_t;

    typedef struct packed {
        logic [TOOTH_W-1:0]       tooth_index;
        logic [REV_W-1:0]         revolution_count;
        logic                     crank_phase;
        logic                     gap_detected;
        logic [NUM_CYLINDERS-1:0] inject_mask;
        logic [PERIOD_W-1:0]      period_used;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [CYL_W-1:0] cyl;
        logic [POS_W-1:0] pos;
    } tbl_wr_t;

    typedef struct packed {
        logic [POS_W-1:0] target_norm;
        logic [POS_W-1:0] target_gap;
    } match_req_t;

    typedef struct packed {
        logic [NUM_CYLINDERS-1:0] mask_norm;
        logic [NUM_CYLINDERS-1:0] mask_gap;
    } match_rsp_t;

endpackage

/* sv/mtcd_cfg.sv */
`timescale 1ns / 1ps

module mtcd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtcd_pkg::ADDR_W-1:0]     paddr,
    input  logic [mtcd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtcd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output mtcd_pkg::cfg_t                  cfg
);
    import mtcd_pkg::*;

    logic [TOOTH_W-1:0] teeth_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               hall_reg;
    logic               manual_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            teeth_reg  <= TEETH_RESET;
            ratio_reg  <= RATIO_RESET;
            hall_reg   <= 1'b0;
            manual_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TEETH:  teeth_reg  <= pwdata[TOOTH_W-1:0];
                REG_RATIO:  ratio_reg  <= pwdata[RATIO_W-1:0];
                REG_HALL:   hall_reg   <= pwdata[0];
                REG_MANUAL: manual_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TEETH:  prdata = APB_DATA_W'(teeth_reg);
            REG_RATIO:  prdata = APB_DATA_W'(ratio_reg);
            REG_HALL:   prdata = APB_DATA_W'(hall_reg);
            REG_MANUAL: prdata = APB_DATA_W'(manual_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.teeth_per_rev    = teeth_reg;
    assign cfg.gap_ratio_tenths = ratio_reg;
    assign cfg.hall_on_crank    = hall_reg;
    assign cfg.manual_injection = manual_reg;

endmodule

/* sv/mtcd_inreg.sv */
`timescale 1ns / 1ps

module mtcd_inreg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mtcd_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output mtcd_pkg::item_t item
);
    import mtcd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/mtcd_tooth_table.sv */
`timescale 1ns / 1ps

module mtcd_tooth_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtcd_pkg::tbl_wr_t    wr,
    input  mtcd_pkg::match_req_t req,
    output mtcd_pkg::match_rsp_t rsp
);
    import mtcd_pkg::*;

    logic [POS_W-1:0] teeth_reg [NUM_CYLINDERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CYLINDERS; c++)
            begin
                teeth_reg[c] <= '0;
            end
        end
        else if (wr.en && (32'(wr.cyl) < NUM_CYLINDERS))
        begin
            teeth_reg[wr.cyl] <= wr.pos;
        end
    end

    // Both candidate tooth targets are matched in parallel; the engine picks one.
    always_comb
    begin
        for (int c = 0; c < NUM_CYLINDERS; c++)
        begin
            rsp.mask_norm[c] = (teeth_reg[c] == req.target_norm);
            rsp.mask_gap[c]  = (teeth_reg[c] == req.target_gap);
        end
    end

endmodule

/* sv/mtcd_engine.sv */
`timescale 1ns / 1ps

module mtcd_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtcd_pkg::cfg_t       cfg,
    input  logic                 item_valid,
    input  mtcd_pkg::item_t      item,
    output logic                 advance,
    output mtcd_pkg::tbl_wr_t    tbl_wr,
    output mtcd_pkg::match_req_t req,
    input  mtcd_pkg::match_rsp_t rsp,
    output logic                 res_valid,
    input  logic                 res_ready,
    output mtcd_pkg::result_t    res
);
    import mtcd_pkg::*;

    logic [PERIOD_W-1:0] last_period_reg, last_period_next;
    logic [TOOTH_W-1:0]  tooth_reg, tooth_next;
    logic [REV_W-1:0]    rev_reg, rev_next;
    logic                phase_reg, phase_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic [PERIOD_W-1:0] used;
    logic [PROD_W-1:0]   lhs;
    logic [PROD_W-1:0]   rhs;
    logic                normal;
    logic [TOOTH_W-1:0]  count_inc;
    logic                phase_gap;

    assign advance        = item_valid && (!res_valid_reg || res_ready);
    assign res_valid_next = advance ? 1'b1 : (res_valid_reg && !res_ready);

    assign used      = (item.period == '0) ? last_period_reg : item.period;
    assign lhs       = PROD_W'({used, 3'b000}) + PROD_W'({used, 1'b0});
    assign rhs       = PROD_W'(cfg.gap_ratio_tenths) * PROD_W'(last_period_reg);
    assign normal    = (lhs < rhs) && (tooth_reg < cfg.teeth_per_rev);
    assign count_inc = tooth_reg + TOOTH_W'(1);
    assign phase_gap = cfg.hall_on_crank && !phase_reg;

    assign req.target_norm = POS_W'(count_inc)
                           + (phase_reg ? POS_W'(cfg.teeth_per_rev) : '0);
    assign req.target_gap  = phase_gap ? POS_W'(cfg.teeth_per_rev) : '0;

    assign tbl_wr.en  = advance && (item.mode == MODE_TABLE);
    assign tbl_wr.cyl = item.cyl_index;
    assign tbl_wr.pos = item.tooth_position;

    always_comb
    begin
        last_period_next = last_period_reg;
        tooth_next       = tooth_reg;
        rev_next         = rev_reg;
        phase_next       = phase_reg;
        res_next         = '0;
        case (item.mode)
            MODE_TOOTH:
            begin
                last_period_next     = used;
                res_next.period_used = used;
                if (normal)
                begin
                    tooth_next = count_inc;
                    if (!cfg.manual_injection)
                    begin
                        res_next.inject_mask = rsp.mask_norm;
                    end
                end
                else
                begin
                    tooth_next            = '0;
                    rev_next              = rev_reg + REV_W'(1);
                    phase_next            = phase_gap;
                    res_next.gap_detected = 1'b1;
                    if (!cfg.manual_injection)
                    begin
                        res_next.inject_mask = rsp.mask_gap;
                    end
                end
            end
            MODE_CAM:
            begin
                phase_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        res_next.tooth_index      = tooth_next;
        res_next.revolution_count = rev_next;
        res_next.crank_phase      = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_period_reg <= '0;
            tooth_reg       <= '0;
            rev_reg         <= '0;
            phase_reg       <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                last_period_reg <= last_period_next;
                tooth_reg       <= tooth_next;
                rev_reg         <= rev_next;
                phase_reg       <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_gap_bumps_rev: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item.mode == MODE_TOOTH) && !normal
        |=> (rev_reg == $past(rev_reg) + REV_W'(1)) && (tooth_reg == '0))
        else $error("gap did not bump the revolution counter");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_reg.tooth_index == tooth_reg)
                    && (res_reg.revolution_count == rev_reg)
                    && (res_reg.crank_phase == phase_reg))
        else $error("result does not match the updated state");

    a_cam_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item.mode == MODE_CAM) |=> phase_reg && !res_reg.gap_detected)
        else $error("secondary edge did not set the phase");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tooth_reg) && $stable(rev_reg) && $stable(last_period_reg))
        else $error("state changed without an item");
`endif

endmodule

/* sv/missing_tooth_crank_decoder.sv */
`timescale 1ns / 1ps
// An accepted input beat is held in the input register; its result beat is offered from the result register.
// Throughput: one item per cycle while the output is not stalled; the gap compare, the count
// update and the cylinder match are combinational between the input and result registers.
// Reset clears the tooth count, revolution counter, phase, last interval and the
// injection tooth table, and restores the configuration registers to their defaults.

module missing_tooth_crank_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // period, cyl_index, tooth_position from bit 0 up; zero filled.
    input  logic [mtcd_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode.
    input  logic [mtcd_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tooth_index, revolution_count, crank_phase, gap_detected, inject_mask,
    // period_used from bit 0 up; zero filled.
    output logic [mtcd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtcd_pkg::ADDR_W-1:0]     paddr,
    input  logic [mtcd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtcd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mtcd_pkg::*;

    cfg_t       cfg;
    item_t      in_item;
    item_t      item;
    logic       item_valid;
    logic       advance;
    tbl_wr_t    tbl_wr;
    match_req_t req;
    match_rsp_t rsp;
    result_t    res;

    assign in_item.mode           = mode_t'(s_tuser[1:0]);
    assign in_item.period         = s_tdata[PERIOD_W-1:0];
    assign in_item.cyl_index      = s_tdata[PERIOD_W+CYL_W-1:PERIOD_W];
    assign in_item.tooth_position = s_tdata[PERIOD_W+CYL_W+POS_W-1:PERIOD_W+CYL_W];

    mtcd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mtcd_inreg u_inreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mtcd_tooth_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .req   (req),
        .rsp   (rsp)
    );

    mtcd_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .tbl_wr     (tbl_wr),
        .req        (req),
        .rsp        (rsp),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.period_used, res.inject_mask, res.gap_detected,
                      res.crank_phase, res.revolution_count, res.tooth_index};

endmodule

/* dv/crank_decoder_checker.sv */
`timescale 1ns / 1ps

module crank_decoder_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mtcd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [mtcd_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mtcd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtcd_pkg::ADDR_W-1:0]     paddr,
    input  logic [mtcd_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              pending
);
    import mtcd_pkg::*;

    logic [TOOTH_W-1:0]  teeth;
    logic [RATIO_W-1:0]  ratio;
    logic                hall;
    logic                manual;

    logic [PERIOD_W-1:0] last_per;
    logic [TOOTH_W-1:0]  tooth_cnt;
    logic [REV_W-1:0]    rev_cnt;
    logic                phase;
    logic [POS_W-1:0]    inj_tbl [NUM_CYLINDERS];

    result_t             wheel_results [$];

    function automatic result_t crank_step(input logic [1:0] mode,
                                           input logic [PERIOD_W-1:0] per,
                                           input logic [CYL_W-1:0] cyl,
                                           input logic [POS_W-1:0] pos);
        result_t             r;
        logic [PERIOD_W-1:0] prev;
        logic [63:0]         lhs;
        logic [63:0]         rhs;
        logic [POS_W:0]      target;
        int                  c;
        r = '0;
        case (mode)
            MODE_TOOTH:
            begin
                prev = last_per;
                r.period_used = (per == '0) ? prev : per;
                last_per = r.period_used;
                lhs = 64'(r.period_used) * 64'd10;
                rhs = 64'(ratio) * 64'(prev);
                if (lhs < rhs && tooth_cnt < teeth)
                begin
                    tooth_cnt = tooth_cnt + 1'b1;
                end
                else
                begin
                    r.gap_detected = 1'b1;
                    tooth_cnt = '0;
                    phase = hall ? ~phase : 1'b0;
                    rev_cnt = rev_cnt + 1'b1;
                end
                if (!manual)
                begin
                    target = (POS_W + 1)'(tooth_cnt) + (phase ? (POS_W + 1)'(teeth) : '0);
                    for (c = 0; c < NUM_CYLINDERS; c++)
                    begin
                        if ({1'b0, inj_tbl[c]} == target)
                        begin
                            r.inject_mask[c] = 1'b1;
                        end
                    end
                end
            end
            MODE_CAM:
            begin
                phase = 1'b1;
            end
            MODE_TABLE:
            begin
                if (cyl < NUM_CYLINDERS)
                begin
                    inj_tbl[cyl] = pos;
                end
            end
            default:
            begin
            end
        endcase
        r.tooth_index = tooth_cnt;
        r.revolution_count = rev_cnt;
        r.crank_phase = phase;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [PERIOD_W-1:0] want,
                                 input logic [PERIOD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        int      c;
        if (!rst_n)
        begin
            teeth = TEETH_RESET;
            ratio = RATIO_RESET;
            hall = 1'b0;
            manual = 1'b0;
            last_per = '0;
            tooth_cnt = '0;
            rev_cnt = '0;
            phase = 1'b0;
            for (c = 0; c < NUM_CYLINDERS; c++)
            begin
                inj_tbl[c] = '0;
            end
            wheel_results.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_TEETH:  teeth = pwdata[TOOTH_W-1:0];
                    REG_RATIO:  ratio = pwdata[RATIO_W-1:0];
                    REG_HALL:   hall = pwdata[0];
                    REG_MANUAL: manual = pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (wheel_results.size() == 0)
                begin
                    $error("Result beat arrived with no expected result pending.");
                    mismatches++;
                end
                else
                begin
                    want = wheel_results.pop_front();
                    got.tooth_index = m_tdata[7:0];
                    got.revolution_count = m_tdata[23:8];
                    got.crank_phase = m_tdata[24];
                    got.gap_detected = m_tdata[25];
                    got.inject_mask = m_tdata[37:26];
                    got.period_used = m_tdata[69:38];
                    compare_field("tooth_index", PERIOD_W'(want.tooth_index),
                                  PERIOD_W'(got.tooth_index));
                    compare_field("revolution_count", PERIOD_W'(want.revolution_count),
                                  PERIOD_W'(got.revolution_count));
                    compare_field("crank_phase", PERIOD_W'(want.crank_phase),
                                  PERIOD_W'(got.crank_phase));
                    compare_field("gap_detected", PERIOD_W'(want.gap_detected),
                                  PERIOD_W'(got.gap_detected));
                    compare_field("inject_mask", PERIOD_W'(want.inject_mask),
                                  PERIOD_W'(got.inject_mask));
                    compare_field("period_used", want.period_used, got.period_used);
                end
            end
            if (s_tvalid && s_tready)
            begin
                wheel_results.push_back(crank_step(s_tuser, s_tdata[31:0], s_tdata[35:32],
                                                   s_tdata[44:36]));
            end
            pending = wheel_results.size();
        end
    end

endmodule

/* dv/missing_tooth_crank_decoder_test.sv */
`timescale 1ns / 1ps

module missing_tooth_crank_decoder_test;
    import mtcd_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int LONG_HOLD = 64;
    localparam int CYCLE_LIMIT = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int sent_beats;
    int settings_used;
    int cycles = 0;
    int wheel_teeth;
    bit quiet_run;
    bit long_hold_done = 1'b0;

    missing_tooth_crank_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    crank_decoder_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("missing_tooth_crank_decoder_test: done, errors");
            $finish;
        end
    end

    // The output side stalls in short bursts, and once for a long stretch so that
    // the block fills up and pushes back on its input.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && sent_beats >= 300)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else if (!quiet_run && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [1:0] mode, input logic [PERIOD_W-1:0] per,
                             input logic [CYL_W-1:0] cyl, input logic [POS_W-1:0] pos);
        if (!quiet_run && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = {3'b000, pos, cyl, per};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent_beats++;
        @(negedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_W'(idx) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic apply_setting(input int teeth, input int ratio, input bit hall,
                                 input bit manual);
        s_tvalid = 1'b0;
        wait_drained();
        apb_write(REG_TEETH, APB_DATA_W'(teeth));
        apb_write(REG_RATIO, APB_DATA_W'(ratio));
        apb_write(REG_HALL, APB_DATA_W'(hall));
        apb_write(REG_MANUAL, APB_DATA_W'(manual));
        wheel_teeth = teeth;
        settings_used++;
    endtask

    function automatic int unsigned pick_base();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 64);
            1:       return $urandom_range(65, 100000);
            2:       return $urandom_range(100001, 32'h0100_0000);
            default: return $urandom_range(32'h0100_0001, 32'h5000_0000);
        endcase
    endfunction

    task automatic directed_items();
        send_beat(MODE_TABLE, '0, 4'd0, 9'd0);
        send_beat(MODE_TABLE, '0, 4'd1, 9'd1);
        send_beat(MODE_TABLE, '0, 4'd11, 9'd511);
        send_beat(MODE_TABLE, '0, 4'd5, 9'd61);
        send_beat(MODE_TABLE, '0, 4'd12, 9'd3);
        send_beat(MODE_TABLE, '0, 4'd15, 9'd7);
        send_beat(MODE_TOOTH, 32'd0, '0, '0);
        send_beat(MODE_TOOTH, 32'd100, '0, '0);
        send_beat(MODE_TOOTH, 32'd100, '0, '0);
        send_beat(MODE_TOOTH, 32'd0, '0, '0);
        send_beat(MODE_TOOTH, 32'd139, '0, '0);
        send_beat(MODE_TOOTH, 32'd100, '0, '0);
        send_beat(MODE_TOOTH, 32'd140, '0, '0);
        send_beat(MODE_TOOTH, 32'hFFFF_FFFF, '0, '0);
        send_beat(MODE_TOOTH, 32'hFFFF_FFFF, '0, '0);
        send_beat(MODE_TOOTH, 32'hFFFF_FFFE, '0, '0);
        send_beat(MODE_CAM, 32'hFFFF_FFFF, 4'hF, 9'h1FF);
        send_beat(MODE_TOOTH, 32'd0, '0, '0);
        send_beat(MODE_SPARE, 32'hFFFF_FFFF, 4'hF, 9'h1FF);
        send_beat(MODE_SPARE, 32'd0, 4'd0, 9'd0);
        send_beat(MODE_TOOTH, 32'd1, '0, '0);
        send_beat(MODE_TOOTH, 32'd1, '0, '0);
        send_beat(MODE_TOOTH, 32'd1, '0, '0);
    endtask

    // Mostly a turning wheel with jittered teeth and a long gap interval once per
    // revolution, mixed with cam edges, table writes and stray intervals.
    task automatic spin_wheel(input int count);
        int unsigned base;
        int unsigned jitter;
        int unsigned per;
        int          teeth_seen;
        int          k;
        int          span;
        base = pick_base();
        teeth_seen = 0;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 24))
                0:
                begin
                    send_beat(MODE_CAM, $urandom(), CYL_W'($urandom()), POS_W'($urandom()));
                end
                1, 2:
                begin
                    span = 2 * wheel_teeth + 1;
                    if (span > 511 || $urandom_range(0, 3) == 0)
                    begin
                        span = 511;
                    end
                    send_beat(MODE_TABLE, $urandom(), CYL_W'($urandom_range(0, 15)),
                              POS_W'($urandom_range(0, span)));
                end
                3:
                begin
                    send_beat(MODE_SPARE, $urandom(), CYL_W'($urandom()), POS_W'($urandom()));
                end
                4:
                begin
                    send_beat(MODE_TOOTH, 32'd0, CYL_W'($urandom()), POS_W'($urandom()));
                end
                5:
                begin
                    send_beat(MODE_TOOTH, $urandom(), CYL_W'($urandom()), POS_W'($urandom()));
                end
                6:
                begin
                    base = pick_base();
                    teeth_seen = 0;
                end
                default:
                begin
                    jitter = base / 32;
                    if (teeth_seen + 1 >= wheel_teeth)
                    begin
                        per = base * 2 + $urandom_range(0, base);
                        teeth_seen = 0;
                    end
                    else
                    begin
                        per = base - jitter + $urandom_range(0, 2 * jitter);
                        teeth_seen++;
                    end
                    send_beat(MODE_TOOTH, per, CYL_W'($urandom()), POS_W'($urandom()));
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent_beats = 0;
        settings_used = 1;
        wheel_teeth = int'(TEETH_RESET);
        quiet_run = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_items();
        spin_wheel(200);
        apply_setting(12, 10, 1'b1, 1'b0);
        spin_wheel(230);
        apply_setting(255, 40, 1'b1, 1'b0);
        spin_wheel(400);
        apply_setting(1, 25, 1'b0, 1'b1);
        spin_wheel(100);
        apply_setting(0, 14, 1'b1, 1'b0);
        spin_wheel(60);
        apply_setting(36, 17, 1'b1, 1'b0);
        quiet_run = 1'b1;
        spin_wheel(360);

        s_tvalid = 1'b0;
        wait_drained();
        repeat (12) @(negedge clk);
        $display("Drove %0d beats over %0d register settings, with a %0d-cycle output hold-off.",
                 sent_beats, settings_used, LONG_HOLD);
        $display("Covered tooth, cam, table and spare modes across teeth counts from 0 to 255.");
        if (mismatches == 0)
        begin
            $display("missing_tooth_crank_decoder_test: done, clean");
        end
        else
        begin
            $display("missing_tooth_crank_decoder_test: done, errors");
        end
        $finish;
    end

endmodule
